// ----- rtl/core/ip_prefix_acl_first_match_unit_macros.svh -----
// Assertion macros shared by the checker.
`ifndef IP_PREFIX_ACL_FIRST_MATCH_UNIT_MACROS_SVH
`define IP_PREFIX_ACL_FIRST_MATCH_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ACL_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("acl check failed");

// Next-cycle implication, disabled during reset.
`define ACL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("acl check failed");

`endif

// ----- rtl/core/ipacl_pkg.sv -----
package ipacl_pkg;

	localparam int MAX_RULES_DEF = 128;

	typedef enum logic [1:0] {
		ACT_CLEAR  = 2'd0,
		ACT_ADD    = 2'd1,
		ACT_LOOKUP = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_NOMASK  = 2'd2,
		ST_EMPTY   = 2'd3
	} status_t;

	localparam logic [30:0] EMPTY_PERMS = 31'h7fffff;
	localparam logic [7:0]  V4_MAX_BITS = 8'd32;
	localparam logic [7:0]  V6_MAX_BITS = 8'd128;
	localparam int          ADDR_BYTES  = 16;

	typedef struct packed {
		logic [127:0] addr;
		logic [4:0]   full_bytes;
		logic [7:0]   pmask;
		logic [30:0]  perms;
	} rule_t;

	typedef struct packed {
		logic [30:0] perms;
		logic        matched;
		logic [6:0]  index;
		status_t     status;
	} result_t;

endpackage

// ----- rtl/core/ipacl_ram.sv -----
module ipacl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/core/ipacl_match.sv -----
// Prefix compare of one stored rule against a lookup address.
module ipacl_match
	import ipacl_pkg::*;
(
	input  rule_t        rule,
	input  logic [127:0] addr,
	output logic         hit
);

	logic [ADDR_BYTES-1:0] byte_ok;
	logic [4:0]            full;
	logic [7:0]            rule_byte;
	logic [7:0]            addr_byte;
	logic                  part_ok;

	always_comb begin
		full = (rule.full_bytes > 5'd16) ? 5'd16 : rule.full_bytes;
		for (int k = 0; k < ADDR_BYTES; k++) begin
			byte_ok[k] = (rule.addr[127-8*k -: 8] == addr[127-8*k -: 8]) ||
				(5'(k) >= full);
		end
		rule_byte = 8'h00;
		addr_byte = 8'h00;
		for (int k = 0; k < ADDR_BYTES; k++) begin
			if (full[3:0] == 4'(k)) begin
				rule_byte = rule.addr[127-8*k -: 8];
				addr_byte = addr[127-8*k -: 8];
			end
		end
		part_ok = (rule.pmask == 8'h00) || (full == 5'd16) ||
			(rule_byte == (addr_byte & rule.pmask));
		hit = (&byte_ok) && part_ok;
	end

endmodule

// ----- rtl/core/ip_prefix_acl_first_match_unit.sv -----
// First-match prefix ACL: clear, add and lookup on one item channel.
// A clear, an add or a lookup on an empty table goes from S_IDLE straight to S_PUT;
// any other lookup scans the rules in S_SCAN, stopping at the first hit or the
// last rule, then goes to S_PUT. One item in flight: in_ready is high only in
// S_IDLE; S_PUT waits for a free output register before returning to S_IDLE.
// Reset (async, active low) empties the table; the rule RAM is not cleared.
module ip_prefix_acl_first_match_unit
	import ipacl_pkg::*;
#(
	parameter int MAX_RULES = MAX_RULES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [63:0] addr_hi,
	input  logic [63:0] addr_lo,
	input  logic        is_ipv4,
	input  logic [7:0]  prefix_len,
	input  logic [30:0] perm_mask,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [30:0] permissions,
	output logic        matched_rule,
	output logic [6:0]  rule_index,
	output logic [1:0]  status
);

	// Index and count widths; the count must hold MAX_RULES itself.
	localparam int IW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
	localparam int CW = $clog2(MAX_RULES + 1);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_PUT  = 3'b100
	} state_t;

	state_t        state_q;
	logic [CW-1:0] count_q;
	logic [IW-1:0] scan_q;
	logic [127:0]  key_q;     // lookup address held during the scan
	result_t       res_q;     // result waiting for the output register
	result_t       out_q;
	logic          out_valid_q;

	logic          accept;
	logic          table_full;
	logic          table_empty;
	logic          last_rule;
	logic          hit;
	logic          out_free;
	logic [IW-1:0] raddr;
	logic [$bits(rule_t)-1:0] rdata;
	rule_t         rd_rule;
	rule_t         wr_rule;
	logic          we;
	logic [7:0]    bits_clamp;
	logic [2:0]    rem;
	logic [7:0]    pm;
	logic [127:0]  keep_mask;
	action_t       act;

	assign act         = action_t'(action);
	assign in_ready    = (state_q == S_IDLE);
	assign accept      = in_valid && in_ready;
	assign table_full  = (count_q == CW'(MAX_RULES));
	assign table_empty = (count_q == '0);
	assign last_rule   = (CW'(scan_q) == count_q - CW'(1));
	assign out_free    = !out_valid_q || out_ready;

	// Rule build for add: clamp the prefix, split into whole bytes and a
	// partial-byte mask, and clear the unmasked bits of the partial byte.
	always_comb begin
		bits_clamp = prefix_len;
		if (is_ipv4 && bits_clamp > V4_MAX_BITS) begin
			bits_clamp = V4_MAX_BITS;
		end
		if (bits_clamp > V6_MAX_BITS) begin
			bits_clamp = V6_MAX_BITS;
		end
		rem = bits_clamp[2:0];
		pm  = (rem == 3'd0) ? 8'h00 : 8'(16'hff00 >> rem);
		for (int k = 0; k < ADDR_BYTES; k++) begin
			keep_mask[127-8*k -: 8] = (rem != 3'd0 && bits_clamp[7:3] == 5'(k)) ?
				pm : 8'hff;
		end
		wr_rule.addr       = {addr_hi, addr_lo} & keep_mask;
		wr_rule.full_bytes = bits_clamp[7:3];
		wr_rule.pmask      = pm;
		wr_rule.perms      = perm_mask;
	end

	assign we = accept && (act == ACT_ADD) && !table_full && (perm_mask != '0);

	// Read address runs one ahead of the rule under compare.
	assign raddr = (state_q == S_IDLE) ? '0 : scan_q + IW'(1);

	ipacl_ram #(
		.WIDTH($bits(rule_t)),
		.DEPTH(MAX_RULES)
	) u_rules (
		.clk   (clk),
		.we    (we),
		.waddr (count_q[IW-1:0]),
		.wdata (wr_rule),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign rd_rule = rule_t'(rdata);

	ipacl_match u_match (
		.rule (rd_rule),
		.addr (key_q),
		.hit  (hit)
	);

	// Sequencer and table count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			scan_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// output register: loaded from S_PUT, emptied on handshake
			if (state_q == S_PUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						scan_q <= '0;
						if (act == ACT_LOOKUP && !table_empty) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_PUT;
						end
						if (act == ACT_CLEAR) begin
							count_q <= '0;
						end
						if (we) begin
							count_q <= count_q + CW'(1);
						end
					end
				end
				S_SCAN: begin
					if (hit || last_rule) begin
						state_q <= S_PUT;
					end else begin
						scan_q <= scan_q + IW'(1);
					end
				end
				S_PUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q         <= {addr_hi, addr_lo};
			res_q.matched <= 1'b0;
			res_q.index   <= '0;
			if (act == ACT_LOOKUP && table_empty) begin
				res_q.perms  <= EMPTY_PERMS;
				res_q.status <= ST_EMPTY;
			end else begin
				res_q.perms <= '0;
				// full table wins over an empty mask
				if (act == ACT_ADD && table_full) begin
					res_q.status <= ST_FULL;
				end else if (act == ACT_ADD && perm_mask == '0) begin
					res_q.status <= ST_NOMASK;
				end else begin
					res_q.status <= ST_OK;
				end
			end
		end
		if (state_q == S_SCAN && hit) begin
			res_q.perms   <= rd_rule.perms;
			res_q.matched <= 1'b1;
			res_q.index   <= 7'(scan_q);
		end
		if (state_q == S_PUT && out_free) begin
			out_q <= res_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign permissions  = out_q.perms;
	assign matched_rule = out_q.matched;
	assign rule_index   = out_q.index;
	assign status       = out_q.status;

endmodule

// ----- rtl/core/ipacl_checker.sv -----
`include "ip_prefix_acl_first_match_unit_macros.svh"

module ipacl_checker
	import ipacl_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [30:0] permissions,
	input logic        matched_rule,
	input logic [6:0]  rule_index,
	input logic [1:0]  status
);

	// A stalled result holds.
	`ACL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(permissions) && $stable(status))
	// One item in flight: no accept right after an accept.
	`ACL_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready)
	// A match always reports status ok.
	`ACL_ASSERT_NOW(a_match_ok, out_valid && matched_rule, status == ST_OK)
	// Empty-table default grant.
	`ACL_ASSERT_NOW(a_empty_dflt, out_valid && status == ST_EMPTY, permissions == EMPTY_PERMS && !matched_rule)
	// No match, no index.
	`ACL_ASSERT_NOW(a_idx_zero, out_valid && !matched_rule, rule_index == 7'd0)

endmodule

bind ip_prefix_acl_first_match_unit ipacl_checker u_ipacl_checker (.*);
